>>> rtl/core/tsi_pkg.sv
// Shared types, constants and elaboration-time helpers for the 3-bar symmetry image block.
// Used by tsi_norm and threebar_symmetry_images; depends on nothing else.
package tsi_pkg;

    // Default coordinate width: signed fixed point, raw integer arithmetic.
    localparam int COORD_WIDTH_DEF = 32;

    // Axis register width and configuration index width.
    localparam int AXIS_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    // Width of the image index and of the result tuser field.
    localparam int IMG_INDEX_WIDTH = 3;
    localparam int IMG_USER_WIDTH  = IMG_INDEX_WIDTH + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_AXIS_X   = 3'd0,
        REG_AXIS_Y   = 3'd1,
        REG_AXIS_Z   = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5
    } cfg_reg_t;

    // Image index codes: identity, 120 and 240 degree turns, then inversions.
    localparam logic [IMG_INDEX_WIDTH-1:0] IMG_ROT0 = 3'd0;
    localparam logic [IMG_INDEX_WIDTH-1:0] IMG_ROT1 = 3'd1;
    localparam logic [IMG_INDEX_WIDTH-1:0] IMG_ROT2 = 3'd2;
    localparam logic [IMG_INDEX_WIDTH-1:0] IMG_INV0 = 3'd3;
    localparam logic [IMG_INDEX_WIDTH-1:0] IMG_INV1 = 3'd4;
    localparam logic [IMG_INDEX_WIDTH-1:0] IMG_LAST = 3'd5;

    // Fraction bits of the unit axis, chosen so that every product fits 64 bits.
    function automatic int kf_of(input int cw);
        int kf;
        kf = 58 - cw;
        if (kf > 30)
        begin
            kf = 30;
        end
        return kf;
    endfunction

    // Integer square root, evaluated at elaboration only.
    function automatic longint unsigned isqrt_const(input longint unsigned val);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = val;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/tsi_norm.sv
// Axis normalization: bit-serial square root of the squared axis length, then
// three bit-serial divisions that give the unit axis. Depends on tsi_pkg.
module tsi_norm
    import tsi_pkg::*;
#(
    parameter int KF = kf_of(COORD_WIDTH_DEF)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [AXIS_WIDTH-1:0] axis_x,
    input  logic signed [AXIS_WIDTH-1:0] axis_y,
    input  logic signed [AXIS_WIDTH-1:0] axis_z,
    output logic                         busy,
    output logic signed [KF+1:0]         k_x,
    output logic signed [KF+1:0]         k_y,
    output logic signed [KF+1:0]         k_z
);

    localparam int KW         = KF + 2;
    localparam int NW         = KF + 32;
    localparam int CNT_W      = $clog2(NW);
    localparam int RAD_W      = 62;
    localparam int SQRT_STEPS = RAD_W / 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIV
    } norm_state_t;

    norm_state_t              state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               idx_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [31:0]              root_reg;
    logic [32:0]              rem_reg;
    logic [NW-1:0]            num_reg;
    logic [KW-2:0]            quo_reg;
    logic signed [KW-1:0]     k_reg [3];

    logic signed [31:0]       sq_x;
    logic signed [31:0]       sq_y;
    logic signed [31:0]       sq_z;
    logic [31:0]              n2;
    logic [34:0]              sq_rem;
    logic [34:0]              sq_trial;
    logic                     sq_ge;
    logic [34:0]              sq_rem_next;
    logic [31:0]              sq_root_next;
    logic [32:0]              dv_rem;
    logic                     dv_ge;
    logic [32:0]              dv_rem_next;
    logic [KW-2:0]            dv_quo_next;
    logic signed [KW-1:0]     dv_k;
    logic signed [AXIS_WIDTH-1:0] a_cur;
    logic signed [AXIS_WIDTH-1:0] a_nxt;
    logic [AXIS_WIDTH-1:0]    mag_first;
    logic [AXIS_WIDTH-1:0]    mag_nxt;

    // Numerator of one rounded division: |a| scaled up plus half the divisor.
    function automatic logic [NW-1:0] num_of(input logic [AXIS_WIDTH-1:0] m,
                                             input logic [31:0] s);
        return (NW'(m) << (15 + KF)) + NW'(s >> 1);
    endfunction

    // Squared axis length.
    always_comb
    begin
        sq_x = axis_x * axis_x;
        sq_y = axis_y * axis_y;
        sq_z = axis_z * axis_z;
        n2   = 32'(sq_x) + 32'(sq_y) + 32'(sq_z);
    end

    // One square root step: two radicand bits, one root bit.
    always_comb
    begin
        sq_rem       = {rem_reg[32:0], rad_reg[RAD_W-1:RAD_W-2]};
        sq_trial     = {1'b0, root_reg, 2'b01};
        sq_ge        = (sq_rem >= sq_trial);
        sq_rem_next  = sq_ge ? (sq_rem - sq_trial) : sq_rem;
        sq_root_next = {root_reg[30:0], sq_ge};
    end

    // One restoring division step; the divisor stays in root_reg.
    always_comb
    begin
        dv_rem      = {rem_reg[31:0], num_reg[NW-1]};
        dv_ge       = (dv_rem >= {1'b0, root_reg});
        dv_rem_next = dv_ge ? (dv_rem - {1'b0, root_reg}) : dv_rem;
        dv_quo_next = {quo_reg[KW-3:0], dv_ge};
    end

    // Component under division and the one after it.
    always_comb
    begin
        case (idx_reg)
            2'd0:    a_cur = axis_x;
            2'd1:    a_cur = axis_y;
            default: a_cur = axis_z;
        endcase
        case (idx_reg)
            2'd0:    a_nxt = axis_y;
            default: a_nxt = axis_z;
        endcase
        mag_first = axis_x[AXIS_WIDTH-1] ? AXIS_WIDTH'(-axis_x) : axis_x;
        mag_nxt   = a_nxt[AXIS_WIDTH-1] ? AXIS_WIDTH'(-a_nxt) : a_nxt;
        dv_k      = a_cur[AXIS_WIDTH-1] ? -KW'({1'b0, dv_quo_next})
                                        : KW'({1'b0, dv_quo_next});
    end

    // Sequencer: square root, then x, y and z divisions; a zero-length axis clears the outputs instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            rad_reg   <= '0;
            root_reg  <= '0;
            rem_reg   <= '0;
            num_reg   <= '0;
            quo_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                k_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (n2 == 32'd0)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                k_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            rad_reg   <= {n2, 30'd0};
                            root_reg  <= '0;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT:
                begin
                    rad_reg  <= rad_reg << 2;
                    rem_reg  <= sq_rem_next[32:0];
                    root_reg <= sq_root_next;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        idx_reg   <= 2'd0;
                        quo_reg   <= '0;
                        num_reg   <= num_of(mag_first, sq_root_next);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    num_reg <= num_reg << 1;
                    rem_reg <= dv_rem_next;
                    quo_reg <= dv_quo_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NW - 1))
                    begin
                        k_reg[idx_reg] <= dv_k;
                        rem_reg        <= '0;
                        quo_reg        <= '0;
                        cnt_reg        <= '0;
                        num_reg        <= num_of(mag_nxt, root_reg);
                        idx_reg        <= idx_reg + 1'b1;
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign k_x  = k_reg[0];
    assign k_y  = k_reg[1];
    assign k_z  = k_reg[2];

endmodule

>>> rtl/core/threebar_symmetry_images.sv
// Top level of the 3-bar symmetry image block: config registers, rotation
// pipeline and the six-image output serializer. Depends on tsi_pkg and tsi_norm.
//
// Each point accepted on the s_ side yields six beats on the m_ side: the
// point turned by 0, 120 and 240 degrees about the configured axis through the
// configured center, then those three points inverted through the center. The
// rotation pipeline is five register stages deep; a point's first image passes
// through those stages, the serializer register and the output register. After
// that one image leaves per cycle while m_tready is high, and the pipeline holds
// while the serializer works through a point's six images. After reset, and
// after every write of an axis register, a bit-serial normalizer computes the
// unit axis with KF = min(58 - COORD_WIDTH, 30) fraction bits; s_tready stays
// low meanwhile. Center writes take effect at once. Configuration may be written
// only while no point is in flight.
module threebar_symmetry_images
    import tsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    // Configuration write channel.
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]                  cfg_index,
    input  logic [COORD_WIDTH-1:0]                      cfg_data,
    // Point input: point_x, point_y, point_z from bit 0 up, zero padded.
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
    // Image output: image_x, image_y, image_z from bit 0 up, zero padded.
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          m_tdata,
    // image_index in the low three bits, clipped above it.
    output logic [IMG_USER_WIDTH-1:0]                   m_tuser,
    // Set on the last of the six images.
    output logic                                        m_tlast
);

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = ((3 * CW + 7) / 8) * 8;
    localparam int KF    = kf_of(CW);
    localparam int KW    = KF + 2;
    localparam int PW    = CW + 1;
    localparam int PRW   = KW + PW;
    localparam int XSW   = PRW + 2;
    localparam int XW    = XSW + 1 - KF;
    localparam int SXW   = KF + 1 + XW;
    localparam int KDW   = KW + XW;
    localparam int AW    = XW + KF + 7;
    localparam int RW    = CW + 3;
    localparam int VW    = CW + 4;
    localparam longint unsigned S_FULL = isqrt_const(64'd3 << (2 * KF - 2));
    localparam logic signed [KF:0]    S_VAL   = (KF + 1)'(S_FULL);
    localparam logic signed [XSW:0]   X_HALF  = (XSW + 1)'(64'd1 << (KF - 1));
    localparam logic signed [AW-1:0]  A_HALF  = AW'(64'd1 << KF);
    localparam logic signed [VW-1:0]  SAT_HI  = {5'b00000, {(CW - 1){1'b1}}};
    localparam logic signed [VW-1:0]  SAT_LO  = {5'b11111, {(CW - 1){1'b0}}};

    // Configuration registers.
    logic signed [AXIS_WIDTH-1:0] axis_reg   [3];
    logic signed [CW-1:0]         center_reg [3];
    logic                         need_norm_reg;
    logic                         cfg_write;
    logic                         axis_write;
    logic                         norm_start;
    logic                         norm_busy;
    logic signed [KW-1:0]         k [3];

    // Pipeline control.
    logic                         en;
    logic                         in_accept;
    logic                         out_load;
    logic                         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Pipeline payload.
    logic signed [CW-1:0]         pt1_reg [3], pt2_reg [3], pt3_reg [3];
    logic signed [CW-1:0]         pt4_reg [3], pt5_reg [3];
    logic signed [PW-1:0]         p1_reg [3], p2_reg [3], p3_reg [3], p4_reg [3];
    logic signed [PRW-1:0]        ca2_reg [3], cb2_reg [3], dt2_reg [3];
    logic signed [XW-1:0]         x3_reg [3];
    logic signed [XW-1:0]         d3_reg;
    logic signed [SXW-1:0]        sx4_reg [3];
    logic signed [KDW-1:0]        kd4_reg [3];
    logic signed [RW-1:0]         r1_5_reg [3], r2_5_reg [3];

    // Serializer.
    logic                         ser_valid_reg;
    logic [IMG_INDEX_WIDTH-1:0]   img_idx_reg;
    logic signed [CW-1:0]         ser_pt_reg [3];
    logic signed [RW-1:0]         ser_r1_reg [3], ser_r2_reg [3];

    // Output register.
    logic                         m_tvalid_reg;
    logic [DW-1:0]                m_tdata_reg;
    logic [IMG_USER_WIDTH-1:0]    m_tuser_reg;
    logic                         m_tlast_reg;

    // Combinational stage results.
    logic signed [CW-1:0]         pt_in [3];
    logic signed [XSW:0]          xs [3];
    logic signed [XSW:0]          ds;
    logic signed [AW-1:0]         acc1 [3], acc2 [3];
    logic signed [AW-1:0]         rnd1 [3], rnd2 [3];
    logic signed [RW-1:0]         rot1 [3], rot2 [3];
    logic signed [VW-1:0]         img_v [3];
    logic signed [RW-1:0]         img_r [3];
    logic signed [CW-1:0]         img_sat [3];
    logic [2:0]                   img_clip;
    logic                         img_inv;

    // Configuration port.
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign axis_write = cfg_write && (cfg_index == REG_AXIS_X || cfg_index == REG_AXIS_Y
                                      || cfg_index == REG_AXIS_Z);
    assign norm_start = need_norm_reg && !norm_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                axis_reg[i]   <= AXIS_WIDTH'(1);
                center_reg[i] <= '0;
            end
            need_norm_reg <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_AXIS_X:   axis_reg[0]   <= cfg_data[AXIS_WIDTH-1:0];
                    REG_AXIS_Y:   axis_reg[1]   <= cfg_data[AXIS_WIDTH-1:0];
                    REG_AXIS_Z:   axis_reg[2]   <= cfg_data[AXIS_WIDTH-1:0];
                    REG_CENTER_X: center_reg[0] <= cfg_data;
                    REG_CENTER_Y: center_reg[1] <= cfg_data;
                    REG_CENTER_Z: center_reg[2] <= cfg_data;
                    default:      ;
                endcase
            end
            need_norm_reg <= axis_write || (need_norm_reg && !norm_start);
        end
    end

    // Unit axis.
    tsi_norm #(
        .KF (KF)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .axis_x (axis_reg[0]),
        .axis_y (axis_reg[1]),
        .axis_z (axis_reg[2]),
        .busy   (norm_busy),
        .k_x    (k[0]),
        .k_y    (k[1]),
        .k_z    (k[2])
    );

    // The pipeline moves as one whenever the serializer can take a point.
    assign out_load  = !m_tvalid_reg || m_tready;
    assign en        = !ser_valid_reg || (out_load && img_idx_reg == IMG_LAST);
    assign s_tready  = en && !need_norm_reg && !norm_busy;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 3 and stage 5 arithmetic.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt_in[i] = s_tdata[i*CW +: CW];
            xs[i]    = (XSW + 1)'(ca2_reg[i]) - (XSW + 1)'(cb2_reg[i]) + X_HALF;
        end
        ds = (XSW + 1)'(dt2_reg[0]) + (XSW + 1)'(dt2_reg[1]) + (XSW + 1)'(dt2_reg[2])
           + X_HALF;
        for (int i = 0; i < 3; i++)
        begin
            acc1[i] = -(AW'(p4_reg[i]) <<< KF) + (AW'(sx4_reg[i]) <<< 1)
                    + (AW'(kd4_reg[i]) <<< 1) + AW'(kd4_reg[i]);
            acc2[i] = -(AW'(p4_reg[i]) <<< KF) - (AW'(sx4_reg[i]) <<< 1)
                    + (AW'(kd4_reg[i]) <<< 1) + AW'(kd4_reg[i]);
            rnd1[i] = (acc1[i] + A_HALF) >>> (KF + 1);
            rnd2[i] = (acc2[i] + A_HALF) >>> (KF + 1);
            rot1[i] = rnd1[i][RW-1:0] + RW'(center_reg[i]);
            rot2[i] = rnd2[i][RW-1:0] + RW'(center_reg[i]);
        end
    end

    // Pipeline payload: offset, products, rounding, products, sums.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pt1_reg[i] <= pt_in[i];
                p1_reg[i]  <= PW'(pt_in[i]) - PW'(center_reg[i]);
                pt2_reg[i] <= pt1_reg[i];
                p2_reg[i]  <= p1_reg[i];
                dt2_reg[i] <= k[i] * p1_reg[i];
                pt3_reg[i] <= pt2_reg[i];
                p3_reg[i]  <= p2_reg[i];
                x3_reg[i]  <= xs[i][XSW:KF];
                pt4_reg[i] <= pt3_reg[i];
                p4_reg[i]  <= p3_reg[i];
                sx4_reg[i] <= S_VAL * x3_reg[i];
                kd4_reg[i] <= k[i] * d3_reg;
                pt5_reg[i] <= pt4_reg[i];
                r1_5_reg[i] <= rot1[i];
                r2_5_reg[i] <= rot2[i];
            end
            ca2_reg[0] <= k[1] * p1_reg[2];
            cb2_reg[0] <= k[2] * p1_reg[1];
            ca2_reg[1] <= k[2] * p1_reg[0];
            cb2_reg[1] <= k[0] * p1_reg[2];
            ca2_reg[2] <= k[0] * p1_reg[1];
            cb2_reg[2] <= k[1] * p1_reg[0];
            d3_reg     <= ds[XSW:KF];
        end
    end

    // Image for the current index: select, invert, saturate.
    always_comb
    begin
        img_inv = (img_idx_reg >= IMG_INV0);
        for (int i = 0; i < 3; i++)
        begin
            case (img_idx_reg)
                IMG_ROT1, IMG_INV1: img_r[i] = ser_r1_reg[i];
                IMG_ROT2, IMG_LAST: img_r[i] = ser_r2_reg[i];
                default:            img_r[i] = RW'(ser_pt_reg[i]);
            endcase
            img_v[i] = img_inv ? ((VW'(center_reg[i]) <<< 1) - VW'(img_r[i]))
                               : VW'(img_r[i]);
            if (img_v[i] > SAT_HI)
            begin
                img_sat[i]  = SAT_HI[CW-1:0];
                img_clip[i] = 1'b1;
            end
            else if (img_v[i] < SAT_LO)
            begin
                img_sat[i]  = SAT_LO[CW-1:0];
                img_clip[i] = 1'b1;
            end
            else
            begin
                img_sat[i]  = img_v[i][CW-1:0];
                img_clip[i] = 1'b0;
            end
        end
    end

    // Serializer and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            img_idx_reg   <= IMG_ROT0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                ser_valid_reg <= v5_reg;
                img_idx_reg   <= IMG_ROT0;
            end
            else if (out_load && ser_valid_reg)
            begin
                img_idx_reg <= img_idx_reg + 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= ser_valid_reg;
            end
        end
    end

    // Serializer and output payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ser_pt_reg[i] <= pt5_reg[i];
                ser_r1_reg[i] <= r1_5_reg[i];
                ser_r2_reg[i] <= r2_5_reg[i];
            end
        end
        if (out_load)
        begin
            m_tdata_reg <= DW'({img_sat[2], img_sat[1], img_sat[0]});
            m_tuser_reg <= {|img_clip, img_idx_reg};
            m_tlast_reg <= (img_idx_reg == IMG_LAST);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
